// File: hdl/wsu_pkg.sv
package wsu_pkg;

    localparam int unsigned LEN_BITS  = 16;
    localparam int unsigned HC_BITS   = 4;

    localparam logic [6:0] CODE_EXT16 = 7'd126;
    localparam logic [6:0] CODE_EXT64 = 7'd127;
    localparam logic [HC_BITS-1:0] HC_EXT16 = 4'd2;
    localparam logic [HC_BITS-1:0] HC_EXT64 = 4'd8;
    localparam logic [HC_BITS-1:0] HC_MASK  = 4'd4;

    localparam logic [1:0] ST_BYTE      = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_LEN     = 6'b000010,
        PH_EXT     = 6'b000100,
        PH_MASK    = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_DONE    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [7:0]          data_byte;
        logic                packet_start;
        logic [LEN_BITS-1:0] packet_len;
    } t_in_item;

    typedef struct packed {
        logic [7:0]          byte_value;
        logic                is_last;
        logic [1:0]          status;
        logic [LEN_BITS-1:0] payload_length;
    } t_result;

endpackage

// File: hdl/wsu_if.sv
interface wsu_in_if;
    logic                         valid;
    logic                         ready;
    logic [7:0]                   data_byte;
    logic                         packet_start;
    logic [wsu_pkg::LEN_BITS-1:0] packet_len;

    modport source(output valid, output data_byte, output packet_start,
                   output packet_len, input ready);
    modport sink(input valid, input data_byte, input packet_start,
                 input packet_len, output ready);
endinterface

interface wsu_out_if;
    logic                         valid;
    logic                         ready;
    logic [7:0]                   byte_value;
    logic                         is_last;
    logic [1:0]                   status;
    logic [wsu_pkg::LEN_BITS-1:0] payload_length;

    modport source(output valid, output byte_value, output is_last,
                   output status, output payload_length, input ready);
    modport sink(input valid, input byte_value, input is_last,
                 input status, input payload_length, output ready);
endinterface

// File: hdl/websocket_frame_unmasker.sv
// Path: an accepted byte is held in the input register, then decoded into the
//   result register once that register can take it.
// Throughput: one byte per cycle; the only limit is the downstream ready.
// Reset: synchronous, active low; clears both handshake stages and returns the
//   frame decoder to idle with all header state zeroed.
module websocket_frame_unmasker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wsu_in_if.sink     i_in,
    wsu_out_if.source  o_out
);

    wsu_pkg::t_in_item in_item;
    wsu_pkg::t_in_item held_item;
    wsu_pkg::t_result  core_res;
    wsu_pkg::t_result  out_res;
    logic              held_valid;
    logic              can_load;
    logic              fire;
    logic              core_valid;
    logic              out_valid;

    assign in_item.data_byte    = i_in.data_byte;
    assign in_item.packet_start = i_in.packet_start;
    assign in_item.packet_len   = i_in.packet_len;

    // Input register: takes a new byte whenever the held one is being decoded.
    wsu_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (in_item),
        .o_ready (i_in.ready),
        .i_take  (can_load),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    // A held byte is decoded only when the result register can take whatever
    // it produces; bytes that produce nothing pass at the same rate.
    assign fire = held_valid && can_load;

    // Frame state and per-byte decode: header parse, length check, unmasking.
    wsu_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (held_item),
        .o_res_valid (core_valid),
        .o_res       (core_res)
    );

    // Result register: parts the decoder from downstream stalls.
    wsu_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (core_valid),
        .i_res      (core_res),
        .i_ready    (o_out.ready),
        .o_can_load (can_load),
        .o_valid    (out_valid),
        .o_res      (out_res)
    );

    assign o_out.valid          = out_valid;
    assign o_out.byte_value     = out_res.byte_value;
    assign o_out.is_last        = out_res.is_last;
    assign o_out.status         = out_res.status;
    assign o_out.payload_length = out_res.payload_length;

endmodule

// File: hdl/wsu_in_stage.sv
module wsu_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  wsu_pkg::t_in_item i_item,
    output logic              o_ready,
    input  logic              i_take,
    output logic              o_valid,
    output wsu_pkg::t_in_item o_item
);

    logic              r_valid;
    wsu_pkg::t_in_item r_item;

    // refill whenever the held item moves on this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// File: hdl/wsu_frame_core.sv
module wsu_frame_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  wsu_pkg::t_in_item i_item,
    output logic              o_res_valid,
    output wsu_pkg::t_result  o_res
);

    wsu_pkg::t_phase                r_phase, n_phase;
    logic [wsu_pkg::HC_BITS-1:0]    r_hc, n_hc;
    logic [wsu_pkg::LEN_BITS-1:0]   r_len, n_len;
    logic                           r_len_big, n_len_big;  // length bits above LEN_BITS set
    logic [31:0]                    r_mask, n_mask;
    logic [wsu_pkg::LEN_BITS-1:0]   r_pidx, n_pidx;
    logic [wsu_pkg::LEN_BITS-1:0]   r_rem, n_rem;

    logic [wsu_pkg::LEN_BITS-1:0]   rem_dec;
    logic [wsu_pkg::HC_BITS-1:0]    hc_dec;
    logic [wsu_pkg::LEN_BITS-1:0]   pidx_inc;
    logic [7:0]                     key_byte;
    logic [6:0]                     code;
    logic                           chk_end;

    assign rem_dec  = (r_rem != '0) ? r_rem - 1'b1 : r_rem;
    assign hc_dec   = r_hc - 1'b1;
    assign pidx_inc = r_pidx + 1'b1;
    assign code     = i_item.data_byte[6:0];

    always_comb begin
        case (r_pidx[1:0])
            2'd0:    key_byte = r_mask[31:24];
            2'd1:    key_byte = r_mask[23:16];
            2'd2:    key_byte = r_mask[15:8];
            default: key_byte = r_mask[7:0];
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_hc      = r_hc;
        n_len     = r_len;
        n_len_big = r_len_big;
        n_mask    = r_mask;
        n_pidx    = r_pidx;
        n_rem     = r_rem;
        chk_end   = 1'b0;
        o_res_valid          = 1'b0;
        o_res.byte_value     = '0;
        o_res.is_last        = 1'b1;
        o_res.status         = wsu_pkg::ST_MALFORMED;
        o_res.payload_length = '0;

        if (i_fire) begin
            if (i_item.packet_start) begin
                n_hc      = '0;
                n_len     = '0;
                n_len_big = 1'b0;
                n_mask    = '0;
                n_pidx    = '0;
                n_rem     = (i_item.packet_len == '0) ? '0 : i_item.packet_len - 1'b1;
                if (n_rem == '0) begin
                    n_phase     = wsu_pkg::PH_DONE;
                    o_res_valid = 1'b1;
                end else begin
                    n_phase = wsu_pkg::PH_LEN;
                end
            end else begin
                case (r_phase)
                    wsu_pkg::PH_PAYLOAD: begin
                        n_rem            = rem_dec;
                        n_pidx           = pidx_inc;
                        o_res_valid      = 1'b1;
                        o_res.byte_value = i_item.data_byte ^ key_byte;
                        o_res.status     = wsu_pkg::ST_BYTE;
                        if (pidx_inc == r_len) begin
                            n_phase              = wsu_pkg::PH_DONE;
                            o_res.payload_length = r_len;
                        end else begin
                            o_res.is_last = 1'b0;
                        end
                    end
                    wsu_pkg::PH_LEN: begin
                        n_rem     = rem_dec;
                        n_len     = '0;
                        n_len_big = 1'b0;
                        chk_end   = 1'b1;
                        if (code == wsu_pkg::CODE_EXT16) begin
                            n_hc    = wsu_pkg::HC_EXT16;
                            n_phase = wsu_pkg::PH_EXT;
                        end else if (code == wsu_pkg::CODE_EXT64) begin
                            n_hc    = wsu_pkg::HC_EXT64;
                            n_phase = wsu_pkg::PH_EXT;
                        end else begin
                            n_len   = wsu_pkg::LEN_BITS'(code);
                            n_hc    = wsu_pkg::HC_MASK;
                            n_phase = wsu_pkg::PH_MASK;
                        end
                    end
                    wsu_pkg::PH_EXT: begin
                        n_rem     = rem_dec;
                        chk_end   = 1'b1;
                        // big-endian: bytes shifted past the top mark an oversize length
                        n_len_big = r_len_big ||
                                    (r_len[wsu_pkg::LEN_BITS-1 -: 8] != 8'd0);
                        n_len     = {r_len[wsu_pkg::LEN_BITS-9:0], i_item.data_byte};
                        n_hc      = hc_dec;
                        if (hc_dec == '0) begin
                            n_hc    = wsu_pkg::HC_MASK;
                            n_phase = wsu_pkg::PH_MASK;
                        end
                    end
                    wsu_pkg::PH_MASK: begin
                        n_rem  = rem_dec;
                        n_mask = {r_mask[23:0], i_item.data_byte};
                        n_hc   = hc_dec;
                        if (hc_dec == '0) begin
                            n_pidx = '0;
                            if (r_len_big || (r_len > rem_dec)) begin
                                n_phase     = wsu_pkg::PH_DONE;
                                o_res_valid = 1'b1;
                            end else if (r_len == '0) begin
                                n_phase      = wsu_pkg::PH_DONE;
                                o_res_valid  = 1'b1;
                                o_res.status = wsu_pkg::ST_EMPTY;
                            end else begin
                                n_phase = wsu_pkg::PH_PAYLOAD;
                            end
                        end else begin
                            chk_end = 1'b1;
                        end
                    end
                    default: begin
                        // idle, finished or unused code: byte ignored
                    end
                endcase
                // packet ran out inside the header
                if (chk_end && (rem_dec == '0)) begin
                    n_phase     = wsu_pkg::PH_DONE;
                    o_res_valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= wsu_pkg::PH_IDLE;
            r_hc      <= '0;
            r_len     <= '0;
            r_len_big <= 1'b0;
            r_mask    <= '0;
            r_pidx    <= '0;
            r_rem     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_hc      <= n_hc;
            r_len     <= n_len;
            r_len_big <= n_len_big;
            r_mask    <= n_mask;
            r_pidx    <= n_pidx;
            r_rem     <= n_rem;
        end
    end

    // payload only entered with a non-zero length that fits the packet
    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == wsu_pkg::PH_PAYLOAD) |-> (r_len != '0) && !r_len_big)
        else $error("payload phase with invalid length");

    a_pidx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == wsu_pkg::PH_PAYLOAD) |-> (r_pidx < r_len))
        else $error("payload index beyond length");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.is_last) |=> (r_phase == wsu_pkg::PH_DONE))
        else $error("final result without frame finish");

    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.packet_start && o_res_valid)
            |-> (o_res.status == wsu_pkg::ST_MALFORMED))
        else $error("result on packet start other than malformed");

endmodule

// File: hdl/wsu_out_stage.sv
module wsu_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  wsu_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_can_load,
    output logic             o_valid,
    output wsu_pkg::t_result o_res
);

    logic             r_valid;
    wsu_pkg::t_result r_res;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// File: tb/wsu_checker.sv
module wsu_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    wsu_in_if    i_in_mon,
    wsu_out_if   i_out_mon,
    output int   o_errors,
    output int   o_pending
);
    import wsu_pkg::*;

    // frame decoder state mirrored from the block
    t_phase          phase;
    logic [3:0]      hdr_left;
    logic [63:0]     len_acc;
    logic [31:0]     key;
    logic [15:0]     pay_idx;
    logic [15:0]     remain;

    t_result         unmasked_q[$];
    int              mismatches = 0;

    assign o_errors = mismatches;

    // one packet byte in, at most one result out
    function automatic bit unmask_step(input t_in_item it, output t_result res);
        logic [1:0] sel;
        logic [7:0] v;
        res = '0;
        res.is_last = 1'b1;
        if (it.packet_start) begin
            hdr_left = '0;
            len_acc  = '0;
            key      = '0;
            pay_idx  = '0;
            remain   = (it.packet_len == 0) ? 16'd0 : it.packet_len - 16'd1;
            if (remain == 0) begin
                phase      = PH_DONE;
                res.status = ST_MALFORMED;
                return 1'b1;
            end
            phase = PH_LEN;
            return 1'b0;
        end

        if (phase != PH_LEN && phase != PH_EXT && phase != PH_MASK && phase != PH_PAYLOAD)
            return 1'b0;

        if (remain != 0)
            remain = remain - 16'd1;

        case (phase)
            PH_PAYLOAD: begin
                sel     = pay_idx[1:0];
                v       = it.data_byte ^ key[31 - 8*sel -: 8];
                pay_idx = pay_idx + 16'd1;
                res.byte_value = v;
                res.status     = ST_BYTE;
                if ({48'd0, pay_idx} == len_acc) begin
                    phase              = PH_DONE;
                    res.payload_length = len_acc[15:0];
                end else begin
                    res.is_last = 1'b0;
                end
                return 1'b1;
            end
            PH_LEN: begin
                len_acc = '0;
                if (it.data_byte[6:0] == CODE_EXT16) begin
                    hdr_left = HC_EXT16;
                    phase    = PH_EXT;
                end else if (it.data_byte[6:0] == CODE_EXT64) begin
                    hdr_left = HC_EXT64;
                    phase    = PH_EXT;
                end else begin
                    len_acc  = {57'd0, it.data_byte[6:0]};
                    hdr_left = HC_MASK;
                    phase    = PH_MASK;
                end
            end
            PH_EXT: begin
                len_acc  = {len_acc[55:0], it.data_byte};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 0) begin
                    hdr_left = HC_MASK;
                    phase    = PH_MASK;
                end
            end
            default: begin
                key      = {key[23:0], it.data_byte};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 0) begin
                    pay_idx = '0;
                    if (len_acc > {48'd0, remain}) begin
                        phase      = PH_DONE;
                        res.status = ST_MALFORMED;
                        return 1'b1;
                    end
                    if (len_acc == 0) begin
                        phase      = PH_DONE;
                        res.status = ST_EMPTY;
                        return 1'b1;
                    end
                    phase = PH_PAYLOAD;
                    return 1'b0;
                end
            end
        endcase

        // packet ran out inside the header
        if (remain == 0) begin
            phase      = PH_DONE;
            res.status = ST_MALFORMED;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : p_watch
        t_in_item it;
        t_result  got;
        t_result  want;
        t_result  pred;
        if (!i_rst_n) begin
            phase    = PH_IDLE;
            hdr_left = '0;
            len_acc  = '0;
            key      = '0;
            pay_idx  = '0;
            remain   = '0;
            unmasked_q.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = {i_out_mon.byte_value, i_out_mon.is_last, i_out_mon.status,
                       i_out_mon.payload_length};
                if (unmasked_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
                end else begin
                    want = unmasked_q.pop_front();
                    check_field("byte_value", want.byte_value, got.byte_value);
                    check_field("is_last", want.is_last, got.is_last);
                    check_field("status", want.status, got.status);
                    check_field("payload_length", want.payload_length, got.payload_length);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                it = {i_in_mon.data_byte, i_in_mon.packet_start, i_in_mon.packet_len};
                if (unmask_step(it, pred))
                    unmasked_q.push_back(pred);
            end
        end
        o_pending = unmasked_q.size();
    end

endmodule

// File: tb/tb_top.sv
module tb_top;
    import wsu_pkg::*;

    // frame byte budget for the random part (ignored noise not counted)
    localparam int N_ITEMS        = 1300;
    // cycles with no item moving on either side before the run is called dead
    localparam int WATCHDOG_LIMIT = 2000;
    // settle time after the last expected result
    localparam int DRAIN_CYCLES   = 50;

    // length encodings of the second header byte
    localparam int FORM_DIRECT = 0;
    localparam int FORM_EXT16  = 1;
    localparam int FORM_EXT64  = 2;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #5 i_clk = ~i_clk;

    wsu_in_if  in_if();
    wsu_out_if out_if();

    int errors;
    int pending;
    int idle_cycles = 0;
    int hold = 0;
    bit quiet = 1'b0;       // no new gaps or stalls begin while set

    logic [7:0] frame_q[$]; // bytes of the packet under construction

    websocket_frame_unmasker u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    wsu_checker u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_mon  (in_if),
        .i_out_mon (out_if),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // Watchdog: any accepted item on either side restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side back-pressure: mostly short runs, now and then a long stall.
    always @(negedge i_clk) begin : p_sink
        int r;
        if (hold != 0) begin
            hold--;
        end else if (quiet) begin
            out_if.ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                out_if.ready <= 1'b1;
                hold = $urandom_range(0, 6);
            end else if (r < 95) begin
                out_if.ready <= 1'b0;
                hold = $urandom_range(0, 3);
            end else begin
                out_if.ready <= 1'b0;
                hold = $urandom_range(10, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_rand(input int n);
        for (int k = 0; k < n; k++)
            frame_q.push_back(8'($urandom));
    endtask

    // Header: opcode byte, length byte (random mask bit), extended length
    // big-endian, four key bytes; then n_pay random payload bytes.
    task automatic build_frame(input int form, input logic [63:0] enc_len,
                               input int n_pay);
        frame_q.delete();
        frame_q.push_back(8'($urandom));
        case (form)
            FORM_EXT16: begin
                frame_q.push_back({1'($urandom), CODE_EXT16});
                frame_q.push_back(enc_len[15:8]);
                frame_q.push_back(enc_len[7:0]);
            end
            FORM_EXT64: begin
                frame_q.push_back({1'($urandom), CODE_EXT64});
                for (int k = 7; k >= 0; k--)
                    frame_q.push_back(enc_len[8*k +: 8]);
            end
            default: begin
                frame_q.push_back({1'($urandom), enc_len[6:0]});
            end
        endcase
        push_rand(4 + n_pay);
    endtask

    // Sends the first n_send bytes of frame_q. packet_len only matters on the
    // start byte, so the other bytes carry random junk there.
    // valid is left high on return; the next call then drives a new byte or a gap, and the end lowers it.
    task automatic send_packet(input logic [15:0] plen, input int n_send,
                               input bit with_start);
        int gap;
        for (int k = 0; k < n_send; k++) begin
            gap = pick_gap();
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            in_if.valid        <= 1'b1;
            in_if.data_byte    <= frame_q[k];
            in_if.packet_start <= with_start && (k == 0);
            in_if.packet_len   <= (with_start && k == 0) ? plen : 16'($urandom);
            @(posedge i_clk);
            while (!in_if.ready)
                @(posedge i_clk);
            @(negedge i_clk);
        end
    endtask

    initial begin : p_stim
        int          r;
        int          form;
        int          n_pay;
        int          hdr;
        int          n_send;
        int          sent;
        logic [63:0] enc_len;
        logic [15:0] plen;

        in_if.valid        = 1'b0;
        in_if.data_byte    = '0;
        in_if.packet_start = 1'b0;
        in_if.packet_len   = '0;
        out_if.ready       = 1'b0;
        i_rst_n            = 1'b0;
        sent               = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed ---
        // zero-length and one-byte packets: malformed on the start byte
        frame_q = {8'hFF};
        send_packet(16'd0, 1, 1'b1);
        frame_q = {8'h00};
        send_packet(16'd1, 1, 1'b1);
        // stray byte while finished: ignored
        frame_q = {8'h5A};
        send_packet(16'hFFFF, 1, 1'b0);
        // empty payload, mask bit set, largest packet_len
        build_frame(FORM_DIRECT, 64'd0, 0);
        frame_q[1] = frame_q[1] | 8'h80;
        send_packet(16'hFFFF, 6, 1'b1);
        // packet ends inside the 8-byte extended length
        build_frame(FORM_EXT64, 64'd1, 0);
        send_packet(16'd3, 3, 1'b1);
        // payload of 5 but only 2 bytes left after the key
        build_frame(FORM_DIRECT, 64'd5, 0);
        send_packet(16'd8, 6, 1'b1);
        // frame cut short by a new packet start
        build_frame(FORM_DIRECT, 64'd3, 3);
        send_packet(16'd9, 2, 1'b1);
        // short good frame
        build_frame(FORM_DIRECT, 64'd2, 2);
        send_packet(16'd8, 8, 1'b1);

        // --- random ---
        while (sent < N_ITEMS) begin
            quiet = ($urandom_range(0, 7) == 0);
            r     = $urandom_range(0, 99);

            // line noise with no packet start: not counted, and ignored unless a frame was left open
            if (r >= 96) begin
                frame_q.delete();
                push_rand($urandom_range(1, 4));
                send_packet(16'd0, frame_q.size(), 1'b0);
                continue;
            end

            // length encoding and value; big lengths kept rare
            case ($urandom_range(0, 9))
                0, 1:    form = FORM_EXT16;
                2:       form = FORM_EXT64;
                default: form = FORM_DIRECT;
            endcase
            if (form == FORM_DIRECT) begin
                case ($urandom_range(0, 19))
                    0:       enc_len = 64'd125;
                    1, 2:    enc_len = 64'($urandom_range(0, 125));
                    default: enc_len = 64'($urandom_range(0, 12));
                endcase
            end else if (form == FORM_EXT16) begin
                case ($urandom_range(0, 29))
                    0:       enc_len = 64'hFFFF;
                    1, 2:    enc_len = 64'($urandom_range(126, 600));
                    default: enc_len = 64'($urandom_range(0, 20));
                endcase
            end else begin
                case ($urandom_range(0, 7))
                    0:       enc_len = '1;
                    1:       enc_len = {32'($urandom), 32'($urandom)};
                    2:       enc_len = {48'd0, 16'($urandom)};
                    default: enc_len = 64'($urandom_range(0, 20));
                endcase
            end
            // too long to carry: the packet is short and the frame malformed
            n_pay = (enc_len <= 64'd600) ? int'(enc_len) : 0;
            build_frame(form, enc_len, n_pay);
            hdr = frame_q.size() - n_pay;

            if (r < 70 || (r < 80 && n_pay == 0)) begin
                // well-formed unless the length is too long to carry, maybe with trailing bytes or an inflated length
                if ($urandom_range(0, 3) == 0)
                    push_rand($urandom_range(1, 3));
                n_send = frame_q.size();
                case ($urandom_range(0, 19))
                    0:       plen = 16'hFFFF;
                    1, 2:    plen = 16'(n_send + $urandom_range(1, 50));
                    default: plen = 16'(n_send);
                endcase
            end else if (r < 80) begin
                // payload claims more than the packet holds
                plen   = 16'(frame_q.size() - $urandom_range(1, n_pay));
                n_send = plen;
            end else if (r < 90) begin
                // packet ends inside the header; bytes past the end are ignored
                plen   = 16'($urandom_range(0, hdr - 1));
                n_send = plen + $urandom_range(0, 2);
                if (n_send < 1)
                    n_send = 1;
                if (n_send > frame_q.size())
                    n_send = frame_q.size();
            end else begin
                // abandoned part way; the next start restarts decoding
                plen   = 16'(frame_q.size());
                n_send = $urandom_range(1, frame_q.size() - 1);
            end
            send_packet(plen, n_send, 1'b1);
            sent += n_send;
        end

        in_if.valid <= 1'b0;
        quiet = 1'b1;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
